// ===== src/sijq_pkg.sv =====
// ----------------------------------------------------------------------------
// sijq_pkg
// Types, command codes and key compare for the sorted insert job queue.
// ----------------------------------------------------------------------------
package sijq_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned NameW = 64;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned CntOutW = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_POP
  } op_e;

  typedef struct packed {
    logic [TimeW-1:0] service;
    logic [TimeW-1:0] arrival;
    logic [NameW-1:0] name;
  } entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    op_e    op;
    entry_t entry;
  } cell_ctrl_t;

  // true when a sorts strictly after b: service, then arrival, then name
  function automatic logic key_after(entry_t a, entry_t b);
    return {a.service, a.arrival, a.name} > {b.service, b.arrival, b.name};
  endfunction

endpackage

// ===== src/sijq_if.sv =====
// ----------------------------------------------------------------------------
// sijq_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface sijq_in_if;
  import sijq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [TimeW-1:0] svc_time;
  logic [TimeW-1:0] arr_time;
  logic [NameW-1:0] job_name;

  modport source (output valid, cmd, svc_time, arr_time, job_name,
                  input ready);
  modport sink   (input valid, cmd, svc_time, arr_time, job_name,
                  output ready);
endinterface

interface sijq_out_if;
  import sijq_pkg::*;
  logic               valid;
  logic               ready;
  logic               popped;
  logic [TimeW-1:0]   out_service;
  logic [TimeW-1:0]   out_arrival;
  logic [NameW-1:0]   out_name;
  logic               is_empty;
  logic [CntOutW-1:0] entry_count;
  logic               overflow;

  modport source (output valid, popped, out_service, out_arrival, out_name,
                  is_empty, entry_count, overflow, input ready);
  modport sink   (input valid, popped, out_service, out_arrival, out_name,
                  is_empty, entry_count, overflow, output ready);
endinterface

// ===== src/sorted_insert_job_queue.sv =====
// A result word appears in the output register in the cycle after its
// command word is accepted. Throughput: one command word per cycle while the
// output is not stalled, set by the compare-and-shift across the cell row.
// Reset clears the entry count and the output valid flag; slot contents are
// not cleared, as only slots below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_insert_job_queue
// Bounded job queue with append, sorted insert and dequeue, built as a row
// of slot cells with a registered result word.
// ----------------------------------------------------------------------------
module sorted_insert_job_queue
  import sijq_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sijq_in_if.sink    in_i,
  sijq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW = (CntW > CntOutW) ? CntW : CntOutW;

  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            full, has_entries;
  logic            overflow;
  logic            do_pop;
  cmd_e            cmd;
  cell_ctrl_t      ctrl;
  entry_t          new_entry;
  entry_t          head_out;
  logic [ExtW-1:0] count_ext;

  entry_t            cell_q [CAPACITY];
  entry_t            cell_d [CAPACITY];
  logic [CAPACITY:0] placed;

  logic               out_valid_q;
  logic               popped_q, is_empty_q, overflow_q;
  entry_t             head_q;
  logic [CntOutW-1:0] count_out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign cmd         = cmd_e'(in_i.cmd);
  assign new_entry   = '{service: in_i.svc_time, arrival: in_i.arr_time,
                         name: in_i.job_name};
  assign full        = (count_q == CntW'(CAPACITY));
  assign has_entries = (count_q != '0);
  assign overflow    = (cmd == CMD_APPEND || cmd == CMD_INSERT) && full;
  assign do_pop      = (cmd == CMD_POP) && has_entries;

  always_comb begin
    ctrl.entry = new_entry;
    ctrl.op    = OP_HOLD;
    count_d    = count_q;
    if (accept) begin
      case (cmd)
        CMD_APPEND: begin
          if (!full) begin
            ctrl.op = OP_APPEND;
            count_d = count_q + 1'b1;
          end
        end
        CMD_INSERT: begin
          if (!full) begin
            ctrl.op = OP_INSERT;
            count_d = count_q + 1'b1;
          end
        end
        CMD_POP: begin
          if (has_entries) begin
            ctrl.op = OP_POP;
            count_d = count_q - 1'b1;
          end
        end
        default: ctrl.op = OP_HOLD;
      endcase
    end
  end

  assign placed[0] = 1'b0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t left, right;
    if (k == 0) begin : g_first
      assign left = new_entry;
    end else begin : g_inner_l
      assign left = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = cell_q[k];
    end else begin : g_inner_r
      assign right = cell_q[k+1];
    end

    sijq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (CntW'(k) < count_q),
      .tail_i    (CntW'(k) == count_q),
      .placed_i  (placed[k]),
      .left_i    (left),
      .right_i   (right),
      .placed_o  (placed[k+1]),
      .entry_o   (cell_q[k]),
      .entry_d_o (cell_d[k])
    );
  end

  // popped word comes from the old head, otherwise the head after this step, or zero when empty
  always_comb begin
    if (do_pop) begin
      head_out = cell_q[0];
    end else if (count_d != '0) begin
      head_out = cell_d[0];
    end else begin
      head_out = '0;
    end
  end

  assign count_ext = ExtW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q    <= do_pop;
      head_q      <= head_out;
      is_empty_q  <= (count_d == '0);
      count_out_q <= count_ext[CntOutW-1:0];
      overflow_q  <= overflow;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.popped      = popped_q;
  assign out_o.out_service = head_q.service;
  assign out_o.out_arrival = head_q.arrival;
  assign out_o.out_name    = head_q.name;
  assign out_o.is_empty    = is_empty_q;
  assign out_o.entry_count = count_out_q;
  assign out_o.overflow    = overflow_q;

endmodule

// ===== src/sijq_cell.sv =====
// ----------------------------------------------------------------------------
// sijq_cell
// One queue slot: compares the incoming entry with its own and either holds,
// loads the new entry, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module sijq_cell
  import sijq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       tail_i,
  input  logic       placed_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  output logic       placed_o,
  output entry_t     entry_o,
  output entry_t     entry_d_o
);

  entry_t entry_q;
  entry_t entry_d;
  logic   take_new;

  // new entry lands in the first slot it does not exceed, or the first free one
  assign take_new = !placed_i && (!occ_i || !key_after(ctrl_i.entry, entry_q));
  assign placed_o = placed_i || take_new;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_APPEND: begin
        if (tail_i) entry_d = ctrl_i.entry;
      end
      OP_INSERT: begin
        if (take_new) begin
          entry_d = ctrl_i.entry;
        end else if (placed_i) begin
          entry_d = left_i;
        end
      end
      OP_POP:  entry_d = right_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule
